// ===== hdl/unpm_pkg.sv =====
// shared types and constants for the alpha unpremultiply pipeline
// no dependencies
package unpm_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_W       = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int NUM_STAGES  = 4;
    localparam int TAB_DEPTH   = 1 << CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [NUM_W-1:0]   t_num;
    typedef logic [RECIP_W-1:0] t_recip;

    // per-stage load enables and occupancy
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } t_pipe_ctl;

endpackage

// ===== hdl/alpha_unpremultiply.sv =====
// an input transfer passes through 4 register stages (s0 to s3) before its output transfer
// throughput: one pixel per cycle while i_stall is low, set by the 4-stage pipeline with one multiply stage
// stalls hold every stage that cannot move on; bubbles are squeezed out
// reset (synchronous, active low) clears only the stage valid bits
// depends on unpm_pkg, unpm_ctrl and unpm_channel
module alpha_unpremultiply
    import unpm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_chan i_alpha_in,
    input  t_chan i_red_in,
    input  t_chan i_green_in,
    input  t_chan i_blue_in,
    output logic  o_valid,
    input  logic  i_stall,
    output t_chan o_red_out,
    output t_chan o_green_out,
    output t_chan o_blue_out,
    output t_chan o_alpha_out,
    output logic  o_clipped
);

    t_pipe_ctl w_ctl;

    t_chan  r_s0_alpha;
    t_chan  r_s1_alpha;
    t_chan  r_s2_alpha;
    t_chan  r_s3_alpha;
    t_recip r_s1_recip;
    logic   r_s3_clipped;

    t_recip w_recip_tab [TAB_DEPTH];
    logic   w_zero_s2;
    logic   w_over_r;
    logic   w_over_g;
    logic   w_over_b;

    // ceil(2^24 / a); entry for zero alpha is never used
    for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_recip
        localparam longint DIV = (gi == 0) ? 1 : gi;
        localparam longint VAL = (gi == 0) ? 0 :
                                 ((64'd1 << RECIP_SHIFT) + DIV - 1) / DIV;
        assign w_recip_tab[gi] = VAL[RECIP_W-1:0];
    end

    unpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_ctl   (w_ctl)
    );

    assign w_zero_s2 = (r_s2_alpha == '0);

    unpm_channel u_red (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_colour   (i_red_in),
        .i_alpha_s0 (r_s0_alpha),
        .i_recip_s1 (r_s1_recip),
        .i_zero_s2  (w_zero_s2),
        .o_over_s2  (w_over_r),
        .o_value    (o_red_out)
    );

    unpm_channel u_green (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_colour   (i_green_in),
        .i_alpha_s0 (r_s0_alpha),
        .i_recip_s1 (r_s1_recip),
        .i_zero_s2  (w_zero_s2),
        .o_over_s2  (w_over_g),
        .o_value    (o_green_out)
    );

    unpm_channel u_blue (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_colour   (i_blue_in),
        .i_alpha_s0 (r_s0_alpha),
        .i_recip_s1 (r_s1_recip),
        .i_zero_s2  (w_zero_s2),
        .o_over_s2  (w_over_b),
        .o_value    (o_blue_out)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[0]) begin
            r_s0_alpha <= i_alpha_in;
        end
        if (w_ctl.load[1]) begin
            r_s1_alpha <= r_s0_alpha;
            r_s1_recip <= w_recip_tab[r_s0_alpha];
        end
        if (w_ctl.load[2]) begin
            r_s2_alpha <= r_s1_alpha;
        end
        if (w_ctl.load[3]) begin
            r_s3_alpha   <= r_s2_alpha;
            // transparent pixels never report clipping
            r_s3_clipped <= ~w_zero_s2 & (w_over_r | w_over_g | w_over_b);
        end
    end

    assign o_valid     = w_ctl.valid[NUM_STAGES-1];
    assign o_alpha_out = r_s3_alpha;
    assign o_clipped   = r_s3_clipped;

    a_clip_saturates : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            (o_red_out == CHAN_MAX || o_green_out == CHAN_MAX || o_blue_out == CHAN_MAX))
        else $error("clipped pixel without a saturated channel");

    a_zero_alpha : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_alpha_out == '0 |->
            (o_red_out == '0 && o_green_out == '0 && o_blue_out == '0 && !o_clipped))
        else $error("transparent pixel has colour or clip flag");

    a_opaque_no_clip : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_alpha_out == CHAN_MAX |-> !o_clipped)
        else $error("opaque pixel reported as clipped");

    a_transfer_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> w_ctl.valid[0])
        else $error("input transfer did not occupy the first stage");

endmodule

// ===== hdl/unpm_ctrl.sv =====
// valid/stall control for the four-stage pipeline
// depends on unpm_pkg
module unpm_ctrl
    import unpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  logic      i_stall,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES:0]   w_ready;

    // a stage may load when empty or when its contents move on
    always_comb begin
        w_ready[NUM_STAGES] = ~i_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_ready[k] = ~r_valid[k] | w_ready[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_ready[k]) begin
                n_valid[k] = (k == 0) ? i_valid : r_valid[(k == 0) ? 0 : k-1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall     = ~w_ready[0];
    assign o_ctl.load  = w_ready[NUM_STAGES-1:0];
    assign o_ctl.valid = r_valid;

endmodule

// ===== hdl/unpm_channel.sv =====
// datapath of one colour channel: numerator, reciprocal multiply, saturation
// depends on unpm_pkg; reciprocal and alpha stages come from the top level
module unpm_channel
    import unpm_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_chan     i_colour,
    input  t_chan     i_alpha_s0,
    input  t_recip    i_recip_s1,
    input  logic      i_zero_s2,
    output logic      o_over_s2,
    output t_chan     o_value
);

    t_chan  r_s0_colour;
    t_num   r_s1_num;
    logic   r_s1_over;
    t_chan  r_s2_quot;
    logic   r_s2_over;
    t_chan  r_s3_value;

    t_num              w_num;
    logic [PROD_W-1:0] w_prod;

    // c*255 + a/2, never above 16 bits
    assign w_num = {r_s0_colour, 8'h00} - {8'h00, r_s0_colour}
                 + {9'h000, i_alpha_s0[CHAN_W-1:1]};

    // reciprocal is rounded up, exact for every 16-bit numerator
    assign w_prod = {{RECIP_W{1'b0}}, r_s1_num} * {{NUM_W{1'b0}}, i_recip_s1};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_s0_colour <= i_colour;
        end
        if (i_ctl.load[1]) begin
            r_s1_num  <= w_num;
            r_s1_over <= r_s0_colour > i_alpha_s0;
        end
        if (i_ctl.load[2]) begin
            r_s2_quot <= w_prod[RECIP_SHIFT +: CHAN_W];
            r_s2_over <= r_s1_over;
        end
        if (i_ctl.load[3]) begin
            if (i_zero_s2) begin
                r_s3_value <= '0;
            end else if (r_s2_over) begin
                r_s3_value <= CHAN_MAX;
            end else begin
                r_s3_value <= r_s2_quot;
            end
        end
    end

    assign o_over_s2 = r_s2_over;
    assign o_value   = r_s3_value;

endmodule
